// ===== rtl/core/lz4fbs_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the LZ4 frame block splitter.
// No dependencies; imported by every module of the block.
package lz4fbs_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int Q_DEPTH           = 2;

  localparam int DATA_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int LEN_W      = 31;
  localparam int FIELD_W    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_ON = 1'd1;

  localparam logic [CFG_DATA_W-1:0] HEADER_SIZE_RESET = 8'd7;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_SIZE    = 5'b00010,
    PH_CONTENT = 5'b00100,
    PH_CHECK   = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

endpackage

// ===== rtl/core/lz4fbs_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts frame bytes, tags each with the saturating stream
// position that follows it and with its header flag. Depends on lz4fbs_pkg.
module lz4fbs_front #(
  parameter int POSITION_BITS = lz4fbs_pkg::POSITION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lz4fbs_pkg::DATA_W-1:0]    in_data_byte,
  input  logic [lz4fbs_pkg::CFG_DATA_W-1:0] header_size,
  input  logic                             q_full,
  output logic                             q_push,
  output logic [lz4fbs_pkg::DATA_W-1:0]    q_data_byte,
  output logic [POSITION_BITS-1:0]         q_pos_next,
  output logic                             q_in_hdr
);
  import lz4fbs_pkg::*;

  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] pos_nxt;
  logic [POSITION_BITS-1:0] pos_inc;

  // position saturates at all ones
  assign pos_inc     = (pos_r == {POSITION_BITS{1'b1}}) ? pos_r : pos_r + 1'b1;
  assign in_stall    = q_full;
  assign q_push      = in_valid && !q_full;
  assign q_data_byte = in_data_byte;
  assign q_pos_next  = pos_inc;
  assign q_in_hdr    = pos_r < POSITION_BITS'(header_size);
  assign pos_nxt     = q_push ? pos_inc : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== rtl/core/lz4fbs_queue.sv =====
`timescale 1ns / 1ps
// Small FIFO between the front end and the parser.
// Depends on lz4fbs_pkg for the default depth.
module lz4fbs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lz4fbs_pkg::Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             not_empty
);
  import lz4fbs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign dout      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");

endmodule

// ===== rtl/core/lz4fbs_back.sv =====
`timescale 1ns / 1ps
// Parser: walks header, size word, content and checksum phases and
// holds the block record in the output register. Depends on lz4fbs_pkg.
module lz4fbs_back #(
  parameter int POSITION_BITS = lz4fbs_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_not_empty,
  output logic                                q_pop,
  input  logic [lz4fbs_pkg::DATA_W-1:0]       q_data_byte,
  input  logic [POSITION_BITS-1:0]            q_pos_next,
  input  logic                                q_in_hdr,
  input  logic                                checksum_on,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_is_compressed,
  output logic [lz4fbs_pkg::FIELD_W-1:0]      out_block_start,
  output logic [lz4fbs_pkg::FIELD_W-1:0]      out_block_end,
  output logic                                out_is_end_mark
);
  import lz4fbs_pkg::*;

  localparam int SUM_W = ((POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W) + 1;
  localparam int EXT_W = (POSITION_BITS > FIELD_W) ? POSITION_BITS : FIELD_W;

  phase_t             phase_r, phase_nxt, eff_phase;
  logic [1:0]         idx_r, idx_nxt;
  logic [23:0]        sw_r, sw_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt, rem_dec;
  logic [FIELD_W-1:0] full_word;
  logic [LEN_W-1:0]   len;
  logic [SUM_W-1:0]   end_sum;
  logic [POSITION_BITS-1:0] end_sat;

  logic                     pend_comp_r, pend_comp_nxt;
  logic [POSITION_BITS-1:0] pend_start_r, pend_start_nxt;
  logic [POSITION_BITS-1:0] pend_end_r, pend_end_nxt;

  logic emit, emit_end;
  logic out_valid_r, out_valid_nxt;
  logic out_comp_r, out_end_mark_r;
  logic [POSITION_BITS-1:0] out_start_r, out_end_r;
  logic [EXT_W-1:0] start_ext, end_ext;

  assign q_pop     = q_not_empty && (!out_valid_r || !out_stall);
  assign full_word = {q_data_byte, sw_r};
  assign len       = full_word[LEN_W-1:0];
  assign end_sum   = SUM_W'(q_pos_next) + SUM_W'(len);
  assign end_sat   = (end_sum > SUM_W'({POSITION_BITS{1'b1}})) ?
                     {POSITION_BITS{1'b1}} : end_sum[POSITION_BITS-1:0];
  assign rem_dec   = (rem_r != '0) ? rem_r - 1'b1 : rem_r;

  always_comb begin
    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    sw_nxt         = sw_r;
    rem_nxt        = rem_r;
    pend_comp_nxt  = pend_comp_r;
    pend_start_nxt = pend_start_r;
    pend_end_nxt   = pend_end_r;
    emit           = 1'b0;
    emit_end       = 1'b0;
    eff_phase      = phase_r;
    // header ends on the first byte at or past header_size
    if (phase_r == PH_HEADER && !q_in_hdr) begin
      eff_phase = PH_SIZE;
    end
    if (q_pop) begin
      unique case (eff_phase)
        PH_HEADER: begin
          phase_nxt = PH_HEADER;
        end
        PH_SIZE: begin
          phase_nxt = PH_SIZE;
          // idx is zero on the first size byte after the header
          case (phase_r == PH_HEADER ? 2'd0 : idx_r)
            2'd0: begin
              sw_nxt  = {16'd0, q_data_byte};
              idx_nxt = 2'd1;
            end
            2'd1: begin
              sw_nxt[15:8] = q_data_byte;
              idx_nxt      = 2'd2;
            end
            2'd2: begin
              sw_nxt[23:16] = q_data_byte;
              idx_nxt       = 2'd3;
            end
            default: begin
              idx_nxt        = 2'd0;
              pend_comp_nxt  = ~full_word[FIELD_W-1];
              pend_start_nxt = q_pos_next;
              pend_end_nxt   = end_sat;
              if (len == '0) begin
                phase_nxt = PH_DONE;
                emit      = 1'b1;
                emit_end  = 1'b1;
              end else begin
                rem_nxt   = len;
                phase_nxt = PH_CONTENT;
              end
            end
          endcase
        end
        PH_CONTENT: begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            emit      = 1'b1;
            idx_nxt   = 2'd0;
            phase_nxt = checksum_on ? PH_CHECK : PH_SIZE;
          end
        end
        PH_CHECK: begin
          if (idx_r != 2'd3) begin
            idx_nxt = idx_r + 1'b1;
          end else begin
            idx_nxt   = 2'd0;
            phase_nxt = PH_SIZE;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sw_r         <= sw_nxt;
    rem_r        <= rem_nxt;
    pend_comp_r  <= pend_comp_nxt;
    pend_start_r <= pend_start_nxt;
    pend_end_r   <= pend_end_nxt;
    if (q_pop && emit) begin
      out_comp_r     <= pend_comp_nxt;
      out_start_r    <= pend_start_nxt;
      out_end_r      <= pend_end_nxt;
      out_end_mark_r <= emit_end;
    end
  end

  assign start_ext         = EXT_W'(out_start_r);
  assign end_ext           = EXT_W'(out_end_r);
  assign out_valid         = out_valid_r;
  assign out_is_compressed = out_comp_r;
  assign out_block_start   = start_ext[FIELD_W-1:0];
  assign out_block_end     = end_ext[FIELD_W-1:0];
  assign out_is_end_mark   = out_end_mark_r;

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE) else $error("left done phase");
  a_end_mark_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_end_mark_r |-> out_start_r == out_end_r)
    else $error("end mark record not empty");
  a_content_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CONTENT |-> rem_r != '0) else $error("content phase with no bytes");
  a_no_emit_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !q_pop) else $error("parser ran over held record");

endmodule

// ===== rtl/core/lz4_frame_block_splitter_unit.sv =====
`timescale 1ns / 1ps
// LZ4 frame block splitter, top level. Instantiates lz4fbs_front,
// lz4fbs_queue and lz4fbs_back; depends on lz4fbs_pkg.
//
// Input channel: one frame byte per item on in_data_byte, in_valid/in_stall.
// Output channel: one block record per item (compressed flag, start and end
// stream positions, end mark flag) on out_*, out_valid/out_stall.
// Config: cfg_wr_en writes cfg_data into register cfg_index
// (0 = header byte count, 1 = block checksum present). Write only when idle.
// Throughput: one byte per cycle, sustained while out_stall stays low, set
// by the parser's single phase/counter update per byte. A record is
// registered: the byte that completes it is tagged and written into the
// FIFO when accepted, and the parser loads the output register when it
// pops that byte. A small FIFO parts the byte tagger from the parser.
// Reset (rst_n low, synchronous): position zero, header skip phase,
// header size 7, checksum off, queue and output register empty.
// When the receiver stalls, the record holds; the parser stops at the next
// byte and the queue fills, after which in_stall rises.
// After the end mark record, further bytes are accepted and dropped.
module lz4_frame_block_splitter_unit #(
  parameter int POSITION_BITS = lz4fbs_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lz4fbs_pkg::DATA_W-1:0]       in_data_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_is_compressed,
  output logic [lz4fbs_pkg::FIELD_W-1:0]      out_block_start,
  output logic [lz4fbs_pkg::FIELD_W-1:0]      out_block_end,
  output logic                                out_is_end_mark,
  input  logic                                cfg_wr_en,
  input  logic [lz4fbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lz4fbs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lz4fbs_pkg::*;

  localparam int QW = DATA_W + POSITION_BITS + 1;

  logic [CFG_DATA_W-1:0] header_size_r, header_size_nxt;
  logic                  checksum_on_r, checksum_on_nxt;

  logic                     q_push, q_pop, q_full, q_not_empty;
  logic [DATA_W-1:0]        f_byte, b_byte;
  logic [POSITION_BITS-1:0] f_pos, b_pos;
  logic                     f_hdr, b_hdr;
  logic [QW-1:0]            q_dout;

  always_comb begin
    header_size_nxt = header_size_r;
    checksum_on_nxt = checksum_on_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HEADER_SIZE: header_size_nxt = cfg_data;
        CFG_CHECKSUM_ON: checksum_on_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_size_r <= HEADER_SIZE_RESET;
      checksum_on_r <= 1'b0;
    end else begin
      header_size_r <= header_size_nxt;
      checksum_on_r <= checksum_on_nxt;
    end
  end

  lz4fbs_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data_byte(in_data_byte),
    .header_size (header_size_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data_byte (f_byte),
    .q_pos_next  (f_pos),
    .q_in_hdr    (f_hdr)
  );

  lz4fbs_queue #(.WIDTH(QW), .DEPTH(Q_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .din      ({f_byte, f_pos, f_hdr}),
    .pop      (q_pop),
    .dout     (q_dout),
    .full     (q_full),
    .not_empty(q_not_empty)
  );

  assign {b_byte, b_pos, b_hdr} = q_dout;

  lz4fbs_back #(.POSITION_BITS(POSITION_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_pop            (q_pop),
    .q_data_byte      (b_byte),
    .q_pos_next       (b_pos),
    .q_in_hdr         (b_hdr),
    .checksum_on      (checksum_on_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_compressed(out_is_compressed),
    .out_block_start  (out_block_start),
    .out_block_end    (out_block_end),
    .out_is_end_mark  (out_is_end_mark)
  );

endmodule

// ===== test/tb_lz4_frame_block_splitter_unit.sv =====
`timescale 1ns / 1ps
// Testbench for lz4_frame_block_splitter_unit: feeds LZ4 frame bytes, predicts the block
// records with a scoreboard class and checks every record. Depends on lz4fbs_pkg.
import lz4fbs_pkg::*;

typedef struct packed {
  logic        compressed;
  logic [31:0] start_pos;
  logic [31:0] stop_pos;
  logic        end_mark;
} block_rec_t;

class splitter_scoreboard;
  logic [7:0]  header_len;
  logic        checksum_on;
  logic [31:0] stream_pos;
  phase_t      phase;
  logic [1:0]  word_idx;
  logic [31:0] size_acc;
  logic [30:0] content_left;
  logic [31:0] rec_start;
  logic [31:0] rec_stop;
  logic        rec_comp;
  block_rec_t  expected_records[$];
  int          failures;
  int          records_seen;

  function new();
    header_len   = HEADER_SIZE_RESET;
    checksum_on  = 1'b0;
    stream_pos   = '0;
    phase        = PH_HEADER;
    word_idx     = '0;
    size_acc     = '0;
    content_left = '0;
    rec_start    = '0;
    rec_stop     = '0;
    rec_comp     = 1'b0;
    failures     = 0;
    records_seen = 0;
  endfunction

  function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? '1 : sum[31:0];
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_HEADER_SIZE) header_len = val;
    else if (idx == CFG_CHECKSUM_ON) checksum_on = val[0];
  endfunction

  function void push_record(logic end_mark);
    block_rec_t rec;
    rec.compressed = rec_comp;
    rec.start_pos  = rec_start;
    rec.stop_pos   = rec_stop;
    rec.end_mark   = end_mark;
    expected_records.push_back(rec);
  endfunction

  // Advance the frame parser by one accepted byte.
  function void note_byte(logic [7:0] b);
    logic [31:0] at;
    logic [30:0] len;
    if (phase == PH_DONE) return;
    at = stream_pos;
    stream_pos = sat_add(at, 32'd1);
    if (phase == PH_HEADER) begin
      if (at < {24'd0, header_len}) return;
      phase = PH_SIZE;
      word_idx = '0;
    end
    case (phase)
      PH_SIZE: begin
        if (word_idx == 2'd0) size_acc = '0;
        size_acc = size_acc | (32'(b) << (8 * word_idx));
        if (word_idx < 2'd3) begin
          word_idx++;
        end else begin
          len = size_acc[30:0];
          word_idx = '0;
          rec_comp = ~size_acc[31];
          rec_start = stream_pos;
          rec_stop = sat_add(stream_pos, {1'b0, len});
          if (len == '0) begin
            phase = PH_DONE;
            push_record(1'b1);
          end else begin
            content_left = len;
            phase = PH_CONTENT;
          end
        end
      end
      PH_CONTENT: begin
        if (content_left > 0) content_left--;
        if (content_left == '0) begin
          push_record(1'b0);
          word_idx = '0;
          phase = checksum_on ? PH_CHECK : PH_SIZE;
        end
      end
      PH_CHECK: begin
        if (word_idx < 2'd3) begin
          word_idx++;
        end else begin
          word_idx = '0;
          phase = PH_SIZE;
        end
      end
      default: phase = PH_DONE;
    endcase
  endfunction

  function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h", $time, name, want, got);
      failures++;
    end
  endfunction

  function void check_record(logic comp, logic [31:0] s, logic [31:0] e, logic endm);
    block_rec_t want;
    records_seen++;
    if (expected_records.size() == 0) begin
      $display("%0t: unexpected record: expected none, actual comp=%0b start=%0d end=%0d mark=%0b",
               $time, comp, s, e, endm);
      failures++;
      return;
    end
    want = expected_records.pop_front();
    cmp_field("is_compressed", 32'(want.compressed), 32'(comp));
    cmp_field("block_start", want.start_pos, s);
    cmp_field("block_end", want.stop_pos, e);
    cmp_field("is_end_mark", 32'(want.end_mark), 32'(endm));
  endfunction
endclass

module tb_lz4_frame_block_splitter_unit;
  localparam int RANDOM_BYTES = 1900;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [DATA_W-1:0]     in_data_byte;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_is_compressed;
  logic [FIELD_W-1:0]    out_block_start;
  logic [FIELD_W-1:0]    out_block_end;
  logic                  out_is_end_mark;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  splitter_scoreboard sb = new();
  logic quiet = 1'b0;
  int   bytes_sent;
  int   blocks_sent;

  lz4_frame_block_splitter_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_is_compressed (out_is_compressed),
    .out_block_start   (out_block_start),
    .out_block_end     (out_block_end),
    .out_is_end_mark   (out_is_end_mark),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= (rst_n && !quiet) ? ($urandom_range(99) < 31) : 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_record(out_is_compressed, out_block_start, out_block_end, out_is_end_mark);
  end

  // Called and returns at a falling edge.
  task automatic push_byte(logic [7:0] b);
    if (!quiet) begin
      while ($urandom_range(99) < 31) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Let the queue and output register empty before touching the registers.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (sb.expected_records.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg_port(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  // Size word, content, optional checksum; may flip the checksum setting mid-content.
  task automatic send_block(int len, bit raw, bit flip_mid);
    logic [31:0] word;
    int cut;
    word = {raw, 31'(len)};
    cut = flip_mid ? $urandom_range(len - 1) : -1;
    for (int i = 0; i < 4; i++) push_byte(word[8*i +: 8]);
    for (int i = 0; i < len; i++) begin
      if (i == cut) begin
        settle_idle();
        write_reg_port(CFG_CHECKSUM_ON, CFG_DATA_W'($urandom_range(1)));
      end
      push_byte(8'($urandom));
    end
    if (sb.checksum_on)
      for (int i = 0; i < 4; i++) push_byte(8'($urandom));
    blocks_sent++;
  endtask

  initial begin
    int r;
    int len;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    bytes_sent   = 0;
    blocks_sent  = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Header length cut short while still in the header: 0 ends it on the next byte.
    write_reg_port(CFG_HEADER_SIZE, 8'd255);
    write_reg_port(CFG_CHECKSUM_ON, 8'd0);
    push_byte(8'h00);
    push_byte(8'hff);
    settle_idle();
    write_reg_port(CFG_HEADER_SIZE, 8'd0);
    send_block(1, 1'b1, 1'b0);
    settle_idle();
    write_reg_port(CFG_CHECKSUM_ON, 8'd1);
    send_block(2, 1'b0, 1'b0);
    send_block(3, 1'b0, 1'b1);

    while (bytes_sent < RANDOM_BYTES) begin
      quiet = (bytes_sent > 700 && bytes_sent < 1000);
      if ($urandom_range(99) < 8) begin
        settle_idle();
        write_reg_port(CFG_HEADER_SIZE, 8'($urandom));
        write_reg_port(CFG_CHECKSUM_ON, CFG_DATA_W'($urandom_range(1)));
      end
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(8, 1);
      else if (r < 95) len = $urandom_range(64, 9);
      else len = $urandom_range(300, 65);
      send_block(len, 1'($urandom), $urandom_range(99) < 10);
    end
    quiet = 1'b0;

    // End mark, then bytes that must be dropped.
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte({1'($urandom), 7'd0});
    repeat (6) push_byte(8'($urandom));

    settle_idle();
    repeat (4) @(negedge clk);
    $display("Covered %0d frame bytes in %0d blocks plus the end mark; %0d records checked.",
             bytes_sent, blocks_sent, sb.records_seen);
    if (sb.failures == 0 && sb.expected_records.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d records still expected", sb.expected_records.size());
    $display("Test completed with failures");
    $finish;
  end
endmodule
